// File: sv/local_variance_map_macros.svh
// assertion helpers for the local variance map
`ifndef LOCAL_VARIANCE_MAP_MACROS_SVH
`define LOCAL_VARIANCE_MAP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LVM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lvm assertion failed");

// next-cycle implication
`define LVM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lvm assertion failed");

`endif

// File: sv/lvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_pkg
// shared types and constants of the local variance map
// ----------------------------------------------------------------------------
package lvm_pkg;

	localparam int H_W     = 12;
	localparam int ROW_W   = 11;
	localparam int WIN_W   = 4;
	localparam int S_W     = 16;
	localparam int Q_W     = 24;
	localparam int NUM_W   = 32;
	localparam int DEN_W   = 16;
	localparam int DIVD_W  = NUM_W + 8;
	localparam int DCNT_W  = 6;
	localparam int VAR_W   = 22;
	localparam int HEIGHT_LIMIT = 2048;

	localparam logic [VAR_W-1:0] FLOOR_CODE = 22'd3;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RDLAST,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic mul;
		logic div_init;
		logic div_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic scan_last;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

// File: sv/lvm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_in_if / lvm_out_if
// request channels of the local variance map
// ----------------------------------------------------------------------------
interface lvm_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] pixel;
	modport source (output valid, output operation, output pixel, input ready);
	modport sink (input valid, input operation, input pixel, output ready);
endinterface

interface lvm_out_if;
	logic        valid;
	logic        ready;
	logic [21:0] variance;
	logic        frame_end;
	modport source (output valid, output variance, output frame_end, input ready);
	modport sink (input valid, input variance, input frame_end, output ready);
endinterface

// File: sv/lvm_ctrl.sv
`timescale 1ns / 1ps
`include "local_variance_map_macros.svh"
// ----------------------------------------------------------------------------
// lvm_ctrl
// sequencer: accept, window scan, multiply, divide, hand over
// ----------------------------------------------------------------------------
module lvm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lvm_pkg::sts_t sts,
	output lvm_pkg::cmd_t cmd
);
	import lvm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.emit) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = ST_RDLAST;
			end
			ST_RDLAST: state_d = ST_MUL;
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`LVM_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
	`LVM_ASSERT_NEXT(a_scan_end, (state_q == ST_SCAN) && sts.scan_last, state_q == ST_RDLAST)
	`LVM_ASSERT_NEXT(a_div_end, (state_q == ST_DIV) && sts.div_last, state_q == ST_DONE)
	`LVM_ASSERT_NEXT(a_no_emit, cmd.accept && !sts.emit, state_q == ST_IDLE)

endmodule

// File: sv/lvm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_dp
// line store, position counters, window accumulation and restoring divider
// ----------------------------------------------------------------------------
module lvm_dp #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_WINDOW = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lvm_pkg::cmd_t                      cmd,
	output lvm_pkg::sts_t                      sts,
	input  logic                               cfg_restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_w,
	input  logic [lvm_pkg::H_W-1:0]            eff_h,
	input  logic [lvm_pkg::WIN_W-1:0]          eff_k,
	input  logic                               in_operation,
	input  logic [7:0]                         in_pixel,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lvm_pkg::VAR_W-1:0]          out_variance,
	output logic                               out_frame_end
);
	import lvm_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int SLW   = $clog2(MAX_WINDOW + 1);
	localparam int SLOTS = 2 ** SLW;
	localparam int CNT_W = WW + H_W;

	logic [7:0] mem [SLOTS*(2**CW)];

	logic [SLW-1:0]   in_slot_q;
	logic [CW-1:0]    in_col_q;
	logic [CNT_W-1:0] recv_q, out_cnt_q;
	logic [ROW_W-1:0] out_row_q;
	logic [CW-1:0]    out_col_q;
	logic [WIN_W-1:0] sy_q, sx_q;
	logic             rd_vld_s1;
	logic [7:0]       rdata_s1;
	logic [S_W-1:0]   acc_s_q;
	logic [Q_W-1:0]   acc_q_q;
	logic [NUM_W-1:0] nq_q, ss_q;
	logic [DEN_W-1:0] den_q;
	logic             small_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic             out_vld_q;
	logic [VAR_W-1:0] var_q;
	logic             fe_q;

	logic [2:0]       half;
	logic [CNT_W-1:0] total, delay, recv_base, recv_next, cnt_base;
	logic             recv_full;
	logic [SLW-1:0]   wslot;
	logic [CW-1:0]    wcol;
	logic signed [ROW_W+2:0] rr;
	logic signed [CW+1:0]    cc;
	logic [ROW_W-1:0] rr_cl;
	logic [CW-1:0]    cc_cl;
	logic [SLW+CW-1:0] raddr;
	logic [7:0]       nn;
	logic [NUM_W-1:0] num;
	logic [DEN_W:0]   shifted;

	assign half      = eff_k[3:1];
	assign total     = CNT_W'(eff_w) * CNT_W'(eff_h);
	assign delay     = CNT_W'(half) * CNT_W'(eff_w) + CNT_W'(half);
	assign recv_full = recv_q >= total;
	assign recv_base = recv_full ? '0 : recv_q;
	assign cnt_base  = recv_full ? '0 : out_cnt_q;
	assign recv_next = recv_base + 1'b1;
	assign wslot     = recv_full ? '0 : in_slot_q;
	assign wcol      = recv_full ? '0 : in_col_q;

	always_comb begin
		if (in_operation == OP_FLUSH) begin
			sts.emit = recv_full && (out_cnt_q < total);
		end else begin
			sts.emit = (cnt_base < total) && (recv_next >= cnt_base + delay + 1'b1);
		end
	end

	assign sts.scan_last = (sy_q == eff_k - 1'b1) && (sx_q == eff_k - 1'b1);
	assign sts.div_last  = dcnt_q == DCNT_W'(DIVD_W - 1);
	assign sts.out_busy  = out_vld_q && !out_ready;

	// clamped window position, edge pixels repeat
	always_comb begin
		rr = $signed({3'b0, out_row_q}) + $signed({{(ROW_W-1){1'b0}}, sy_q})
			- $signed({{ROW_W{1'b0}}, half});
		if (rr < 0) begin
			rr_cl = '0;
		end else if (rr > $signed({2'b0, eff_h}) - 1) begin
			rr_cl = ROW_W'(eff_h - 1'b1);
		end else begin
			rr_cl = rr[ROW_W-1:0];
		end
		cc = $signed({2'b0, out_col_q}) + $signed((CW+2)'(sx_q)) - $signed((CW+2)'(half));
		if (cc < 0) begin
			cc_cl = '0;
		end else if (cc > $signed((CW+2)'(eff_w)) - 1) begin
			cc_cl = CW'(eff_w - 1'b1);
		end else begin
			cc_cl = cc[CW-1:0];
		end
	end

	assign raddr   = {rr_cl[SLW-1:0], cc_cl};
	assign nn      = 8'(eff_k) * 8'(eff_k);
	assign num     = nq_q - ss_q;
	assign shifted = {rem_q, quo_q[DIVD_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.accept && (in_operation == OP_PIXEL)) begin
			mem[{wslot, wcol}] <= in_pixel;
		end
		rdata_s1 <= mem[raddr];
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_slot_q <= '0;
			in_col_q  <= '0;
			recv_q    <= '0;
			out_cnt_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_restart) begin
			in_slot_q <= '0;
			in_col_q  <= '0;
			recv_q    <= '0;
			out_cnt_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cmd.accept && (in_operation == OP_PIXEL)) begin
			recv_q <= recv_next;
			if (recv_full) begin
				out_cnt_q <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end
			if (WW'(wcol) + 1'b1 >= eff_w) begin
				in_col_q  <= '0;
				in_slot_q <= wslot + 1'b1;
			end else begin
				in_col_q  <= wcol + 1'b1;
				in_slot_q <= wslot;
			end
		end else if (cmd.load) begin
			out_cnt_q <= out_cnt_q + 1'b1;
			if (WW'(out_col_q) + 1'b1 >= eff_w) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + 1'b1;
			end else begin
				out_col_q <= out_col_q + 1'b1;
			end
		end
	end

	// window scan and accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sy_q      <= '0;
			sx_q      <= '0;
			rd_vld_s1 <= 1'b0;
			acc_s_q   <= '0;
			acc_q_q   <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.accept) begin
				sy_q    <= '0;
				sx_q    <= '0;
				acc_s_q <= '0;
				acc_q_q <= '0;
			end else begin
				if (cmd.scan_step) begin
					if (sx_q == eff_k - 1'b1) begin
						sx_q <= '0;
						sy_q <= sy_q + 1'b1;
					end else begin
						sx_q <= sx_q + 1'b1;
					end
				end
				if (rd_vld_s1) begin
					acc_s_q <= acc_s_q + S_W'(rdata_s1);
					acc_q_q <= acc_q_q + Q_W'(16'(rdata_s1) * 16'(rdata_s1));
				end
			end
		end
	end

	// products, then restoring division of num*256 by n*n
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			nq_q  <= NUM_W'(nn) * NUM_W'(acc_q_q);
			ss_q  <= NUM_W'(acc_s_q) * NUM_W'(acc_s_q);
			den_q <= DEN_W'(nn) * DEN_W'(nn);
		end
		if (cmd.div_init) begin
			small_q <= (39'(num) * 39'd100) <= 39'(den_q);
			quo_q   <= {num, 8'b0};
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(shifted - {1'b0, den_q});
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
		if (cmd.load) begin
			var_q <= small_q ? FLOOR_CODE : quo_q[VAR_W-1:0];
			fe_q  <= out_cnt_q == total - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_vld_q;
	assign out_variance  = var_q;
	assign out_frame_end = fe_q;

endmodule

// File: sv/local_variance_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_variance_map
// k-by-k local variance of a raster pixel stream, edge pixels repeated
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// pix_in    in   valid / ready    operation, pixel
// var_out   out  valid / ready    variance, frame_end
// apb       in   psel / penable   paddr, pwdata, prdata
//
// a request that gives no result is taken in the idle state
// a request that gives a result runs the window scan, which reads
//   the line store once per window pixel, then a 40-step restoring divider
// the output register lets a new request in while a result waits
// reset clears control state; the line store needs no clearing pass
// a stalled output holds the sequencer before its hand-over only
module local_variance_map #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_WINDOW = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	lvm_in_if.sink      pix_in,
	lvm_out_if.source   var_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lvm_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);

	// configuration registers
	logic [H_W-1:0]   cfg_w_q, cfg_h_q;
	logic [WIN_W-1:0] cfg_k_q;
	logic             wr_en, cfg_restart;
	logic [WW-1:0]    eff_w;
	logic [H_W-1:0]   eff_h;
	logic [WIN_W-1:0] eff_k;
	cmd_t             cmd;
	sts_t             sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	// any write to a known register restarts the frame
	assign cfg_restart = wr_en && (paddr[3:2] inside {REG_WIDTH, REG_HEIGHT, REG_WINDOW});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 12'd640;
			cfg_h_q <= 12'd480;
			cfg_k_q <= 4'd3;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WIDTH:  cfg_w_q <= pwdata[H_W-1:0];
				REG_HEIGHT: cfg_h_q <= pwdata[H_W-1:0];
				REG_WINDOW: cfg_k_q <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(cfg_w_q);
			REG_HEIGHT: prdata = 32'(cfg_h_q);
			REG_WINDOW: prdata = 32'(cfg_k_q);
			default:    prdata = '0;
		endcase
	end

	// out-of-range register values fold into the working range
	always_comb begin
		if (cfg_w_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			eff_h = 12'd1;
		end else if (32'(cfg_h_q) > 32'(HEIGHT_LIMIT)) begin
			eff_h = H_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = cfg_h_q;
		end
		eff_k = cfg_k_q;
		if (32'(eff_k) > 32'(MAX_WINDOW)) eff_k = WIN_W'(MAX_WINDOW);
		if (eff_k < 4'd3) eff_k = 4'd3;
		// even sizes step down to the odd size below
		if (!eff_k[0]) eff_k = eff_k - 1'b1;
	end

	lvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lvm_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_restart   (cfg_restart),
		.eff_w         (eff_w),
		.eff_h         (eff_h),
		.eff_k         (eff_k),
		.in_operation  (pix_in.operation),
		.in_pixel      (pix_in.pixel),
		.out_valid     (var_out.valid),
		.out_ready     (var_out.ready),
		.out_variance  (var_out.variance),
		.out_frame_end (var_out.frame_end)
	);

endmodule
